FILE: src/tgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgb_pkg: shared constants and types for the gap buffer editor
// Holds action and status codes, storage geometry and the command struct.
// ----------------------------------------------------------------------------
package tgb_pkg;
	localparam int BufferDepth = 1024;
	localparam int GapW = $clog2(BufferDepth);
	localparam int PosW = $clog2(BufferDepth + 1);

	localparam logic [3:0] ActInsert   = 4'd0;
	localparam logic [3:0] ActDelete   = 4'd1;
	localparam logic [3:0] ActFwd      = 4'd2;
	localparam logic [3:0] ActBack     = 4'd3;
	localparam logic [3:0] ActFwdWord  = 4'd4;
	localparam logic [3:0] ActBackWord = 4'd5;
	localparam logic [3:0] ActStart    = 4'd6;
	localparam logic [3:0] ActEnd      = 4'd7;
	localparam logic [3:0] ActDelWord  = 4'd8;
	localparam logic [3:0] ActRead     = 4'd9;

	localparam logic [1:0] StOk    = 2'd0;
	localparam logic [1:0] StFull  = 2'd1;
	localparam logic [1:0] StRange = 2'd2;

	typedef struct packed {
		logic [3:0]      action;
		logic [7:0]      char_in;
		logic [GapW-1:0] text_index;
	} cmd_t;

	function automatic logic is_delim(input logic [7:0] c);
		return (c == 8'h20) || (c == 8'h0a);
	endfunction
endpackage
`default_nettype wire

FILE: src/tgb_cmd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgb_cmd_queue: front end command queue
// Accepts commands and holds up to two for the execution engine.
// ----------------------------------------------------------------------------
module tgb_cmd_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  tgb_pkg::cmd_t in_cmd,
	output logic                out_valid,
	input  wire                 out_take,
	output tgb_pkg::cmd_t       out_cmd
);
	tgb_pkg::cmd_t ent_q [2];
	logic          rd_ptr_q, wr_ptr_q;
	logic [1:0]    count_q;
	logic          push, pop;

	assign in_stall  = (count_q == 2'd2);
	assign push      = in_valid && !in_stall;
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_take;
	assign out_cmd   = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd2 |-> !push) else $error("queue overflow");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("bad queue count");
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 2'd0 |-> rd_ptr_q == wr_ptr_q) else $error("pointer slip");
`endif
endmodule
`default_nettype wire

FILE: src/tgb_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgb_engine: back end command executor
// Walks the text store byte by byte for shifts, word moves and reads.
// ----------------------------------------------------------------------------
module tgb_engine (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmd_valid,
	output logic                         cmd_take,
	input  wire  tgb_pkg::cmd_t          cmd,
	output logic                         res_valid,
	input  wire                          res_stall,
	output logic [tgb_pkg::PosW-1:0]     cursor,
	output logic [tgb_pkg::PosW-1:0]     length,
	output logic [7:0]                   read_char,
	output logic [1:0]                   status
);
	localparam logic [3:0] SIdle    = 4'd0;
	localparam logic [3:0] SInsRd   = 4'd1;
	localparam logic [3:0] SInsWr   = 4'd2;
	localparam logic [3:0] SDelRd   = 4'd3;
	localparam logic [3:0] SDelWr   = 4'd4;
	localparam logic [3:0] SFwRd    = 4'd5;
	localparam logic [3:0] SFwChk   = 4'd6;
	localparam logic [3:0] SBkRd    = 4'd7;
	localparam logic [3:0] SBkChk   = 4'd8;
	localparam logic [3:0] SDwRd    = 4'd9;
	localparam logic [3:0] SDwChk   = 4'd10;
	localparam logic [3:0] SReadRd  = 4'd11;
	localparam logic [3:0] SReadOut = 4'd12;
	localparam logic [3:0] SDone    = 4'd13;

	localparam int PosW = tgb_pkg::PosW;
	localparam int GapW = tgb_pkg::GapW;
	localparam logic [PosW-1:0] Depth = PosW'(tgb_pkg::BufferDepth);

	logic [7:0]      mem [tgb_pkg::BufferDepth];
	logic [7:0]      rdata_q;
	logic [3:0]      state_q;
	logic [3:0]      act_q;
	logic [PosW-1:0] cur_q, len_q, ptr_q;
	logic [7:0]      carry_q;
	logic            phase_q;
	logic [7:0]      rd_char_q;
	logic [1:0]      st_q;
	logic            we;
	logic [GapW-1:0] waddr, raddr;
	logic [7:0]      wdata;
	logic            re;
	logic            delim;

	assign delim = tgb_pkg::is_delim(rdata_q);

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[raddr];
	end

	// Memory control per state.
	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = ptr_q[GapW-1:0];
		raddr = ptr_q[GapW-1:0];
		wdata = carry_q;
		case (state_q)
			SInsRd: re = (ptr_q < len_q);
			SInsWr: we = 1'b1;
			SDelRd: begin
				re = 1'b1;
				raddr = GapW'(ptr_q + 1'b1);
			end
			SDelWr: begin
				we = 1'b1;
				wdata = rdata_q;
			end
			SFwRd, SReadRd: re = 1'b1;
			SDwRd: begin
				re = 1'b1;
				raddr = cur_q[GapW-1:0];
			end
			SBkRd: begin
				re = 1'b1;
				raddr = GapW'(ptr_q - 1'b1);
			end
			default: ;
		endcase
	end

	assign cmd_take  = (state_q == SIdle);
	assign res_valid = (state_q == SDone);
	assign cursor    = cur_q;
	assign length    = len_q;
	assign read_char = rd_char_q;
	assign status    = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= SIdle;
			act_q     <= tgb_pkg::ActInsert;
			cur_q     <= '0;
			len_q     <= '0;
			ptr_q     <= '0;
			carry_q   <= '0;
			phase_q   <= 1'b0;
			rd_char_q <= '0;
			st_q      <= tgb_pkg::StOk;
		end else begin
			case (state_q)
				SIdle: if (cmd_valid) begin
					act_q     <= cmd.action;
					rd_char_q <= '0;
					st_q      <= tgb_pkg::StOk;
					phase_q   <= 1'b0;
					ptr_q     <= cur_q;
					carry_q   <= cmd.char_in;
					state_q   <= SDone;
					case (cmd.action)
						tgb_pkg::ActInsert:
							if (len_q == Depth) st_q <= tgb_pkg::StFull;
							else state_q <= SInsRd;
						tgb_pkg::ActDelete:
							if (cur_q < len_q) state_q <= SDelRd;
						tgb_pkg::ActFwd:
							if (cur_q < len_q) cur_q <= cur_q + 1'b1;
						tgb_pkg::ActBack:
							if (cur_q != '0) cur_q <= cur_q - 1'b1;
						tgb_pkg::ActFwdWord:
							if (cur_q < len_q) state_q <= SFwRd;
						tgb_pkg::ActBackWord:
							if (cur_q != '0) state_q <= SBkRd;
						tgb_pkg::ActStart: cur_q <= '0;
						tgb_pkg::ActEnd:   cur_q <= len_q;
						tgb_pkg::ActDelWord:
							if (cur_q < len_q) state_q <= SDwRd;
						tgb_pkg::ActRead: begin
							ptr_q <= PosW'(cmd.text_index);
							if (PosW'(cmd.text_index) < len_q) state_q <= SReadRd;
							else st_q <= tgb_pkg::StRange;
						end
						default: ;
					endcase
				end
				// Shift tail up: read old byte at ptr, write carried byte.
				SInsRd: state_q <= SInsWr;
				SInsWr: begin
					carry_q <= rdata_q;
					if (ptr_q >= len_q) begin
						len_q   <= len_q + 1'b1;
						cur_q   <= cur_q + 1'b1;
						state_q <= SDone;
					end else begin
						ptr_q   <= ptr_q + 1'b1;
						state_q <= SInsRd;
					end
				end
				// Shift tail down by one from ptr.
				SDelRd: begin
					if (ptr_q + 1'b1 >= len_q) begin
						len_q   <= len_q - 1'b1;
						state_q <= (act_q == tgb_pkg::ActDelWord) ? SDwRd : SDone;
					end else begin
						state_q <= SDelWr;
					end
				end
				SDelWr: begin
					ptr_q   <= ptr_q + 1'b1;
					state_q <= SDelRd;
				end
				SFwRd: state_q <= SFwChk;
				SFwChk: begin
					if (!phase_q && !delim) phase_q <= 1'b1;
					if (phase_q && delim) state_q <= SDone;
					else if (ptr_q + 1'b1 >= len_q) begin
						cur_q   <= len_q;
						state_q <= SDone;
					end else begin
						if (!(!phase_q && !delim)) ptr_q <= ptr_q + 1'b1;
						cur_q   <= (!phase_q && !delim) ? cur_q : cur_q + 1'b1;
						state_q <= SFwRd;
					end
					if (phase_q && delim) cur_q <= ptr_q;
				end
				SBkRd: state_q <= SBkChk;
				SBkChk: begin
					if (!phase_q && !delim) begin
						phase_q <= 1'b1;
						state_q <= SBkRd;
					end else if (phase_q && delim) begin
						cur_q   <= ptr_q;
						state_q <= SDone;
					end else if (ptr_q == PosW'(1)) begin
						cur_q   <= '0;
						state_q <= SDone;
					end else begin
						ptr_q   <= ptr_q - 1'b1;
						state_q <= SBkRd;
					end
				end
				SDwRd: begin
					ptr_q   <= cur_q;
					state_q <= SDwChk;
				end
				SDwChk: begin
					if (cur_q >= len_q) state_q <= SDone;
					else if (phase_q && delim) state_q <= SDone;
					else begin
						if (!delim) phase_q <= 1'b1;
						state_q <= SDelRd;
					end
				end
				SReadRd: state_q <= SReadOut;
				SReadOut: begin
					rd_char_q <= rdata_q;
					state_q   <= SDone;
				end
				SDone: if (!res_stall) state_q <= SIdle;
				default: state_q <= SIdle;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cur_le_len: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= len_q) else $error("cursor past length");
	a_len_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= Depth) else $error("length past depth");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(cur_q))
		else $error("result lost");
`endif
endmodule
`default_nettype wire

FILE: src/text_gap_buffer_editor.sv
`timescale 1ns / 1ps
`default_nettype none
// Cursor steps, jumps, rejects go idle to done; read goes via SReadRd and SReadOut.
// Insert and delete shift the tail one byte at a time, each read then written back.
// Word moves and word delete scan stored bytes through the RAM read port.
// Throughput: one command in flight in the engine; a two-entry queue buffers input.
// Reset: arst_n clears cursor, length and control; text contents stay undefined.
// ----------------------------------------------------------------------------
// text_gap_buffer_editor: cursor text buffer editor
// Front command queue feeding a sequential byte-walking execution engine.
// ----------------------------------------------------------------------------
module text_gap_buffer_editor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [3:0]  action,
	input  wire  [7:0]  char_in,
	input  wire  [9:0]  text_index,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [10:0] cursor,
	output logic [10:0] length,
	output logic [7:0]  read_char,
	output logic [1:0]  status
);
	tgb_pkg::cmd_t in_cmd, q_cmd;
	logic          q_valid, q_take;

	// Pack the transaction fields for the queue.
	assign in_cmd = '{action: action, char_in: char_in, text_index: text_index};

	tgb_cmd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_cmd(in_cmd),
		.out_valid(q_valid), .out_take(q_take), .out_cmd(q_cmd)
	);

	// Pop the queue head as the idle engine latches it; the queue keeps
	// accepting while the engine works on the command.
	tgb_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
		.res_valid(out_valid), .res_stall(out_stall),
		.cursor(cursor), .length(length), .read_char(read_char), .status(status)
	);
endmodule
`default_nettype wire

FILE: verif/text_gap_buffer_editor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_gap_buffer_editor_tb: self-checking bench for the gap buffer editor
// Drives edit commands, mirrors the text and cursor, checks every result.
// ----------------------------------------------------------------------------
module text_gap_buffer_editor_tb;
	typedef struct {
		logic [3:0] action;
		logic [7:0] char_in;
		logic [9:0] text_index;
	} edit_cmd_t;

	typedef struct {
		logic [10:0] cursor;
		logic [10:0] length;
		logic [7:0]  read_char;
		logic [1:0]  status;
	} edit_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [3:0]  action = '0;
	logic [7:0]  char_in = '0;
	logic [9:0]  text_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b1;
	logic [10:0] cursor;
	logic [10:0] length;
	logic [7:0]  read_char;
	logic [1:0]  status;

	// Mirror of the editor state.
	byte unsigned mirror_text[$];
	int           mirror_cursor = 0;

	edit_cmd_t    pending_cmds[$];
	edit_result_t expected_results[$];
	int           mismatch_count = 0;
	int           sent_count = 0;
	bit           in_taken = 1'b0;     // input transaction at the last rising edge
	bit           quiet_run = 1'b0;   // window with no idling at all
	bit           hold_started = 1'b0;
	int           hold_off_cycles = 0; // long receiver hold-off

	text_gap_buffer_editor uut (.*);

	always #5 clk = ~clk;

	function automatic bit is_space(byte unsigned c);
		return c == 8'h20 || c == 8'h0a;
	endfunction

	// Apply one command to the mirror and return what the editor should answer.
	function automatic edit_result_t apply_edit(edit_cmd_t c);
		edit_result_t r;
		r.read_char = '0;
		r.status = tgb_pkg::StOk;
		case (c.action)
			tgb_pkg::ActInsert: begin
				if (mirror_text.size() >= tgb_pkg::BufferDepth) r.status = tgb_pkg::StFull;
				else begin
					mirror_text.insert(mirror_cursor, c.char_in);
					mirror_cursor++;
				end
			end
			tgb_pkg::ActDelete:
				if (mirror_cursor < mirror_text.size()) mirror_text.delete(mirror_cursor);
			tgb_pkg::ActFwd:
				if (mirror_cursor < mirror_text.size()) mirror_cursor++;
			tgb_pkg::ActBack:
				if (mirror_cursor > 0) mirror_cursor--;
			tgb_pkg::ActFwdWord: begin
				while (mirror_cursor < mirror_text.size() && is_space(mirror_text[mirror_cursor]))
					mirror_cursor++;
				while (mirror_cursor < mirror_text.size() && !is_space(mirror_text[mirror_cursor]))
					mirror_cursor++;
			end
			tgb_pkg::ActBackWord: begin
				while (mirror_cursor > 0 && is_space(mirror_text[mirror_cursor-1]))
					mirror_cursor--;
				while (mirror_cursor > 0 && !is_space(mirror_text[mirror_cursor-1]))
					mirror_cursor--;
			end
			tgb_pkg::ActStart: mirror_cursor = 0;
			tgb_pkg::ActEnd:   mirror_cursor = mirror_text.size();
			tgb_pkg::ActDelWord: begin
				while (mirror_cursor < mirror_text.size() && is_space(mirror_text[mirror_cursor]))
					mirror_text.delete(mirror_cursor);
				while (mirror_cursor < mirror_text.size() && !is_space(mirror_text[mirror_cursor]))
					mirror_text.delete(mirror_cursor);
			end
			tgb_pkg::ActRead: begin
				if (c.text_index < mirror_text.size()) r.read_char = mirror_text[c.text_index];
				else r.status = tgb_pkg::StRange;
			end
			default: ;
		endcase
		r.cursor = mirror_cursor[10:0];
		r.length = 11'(mirror_text.size());
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	task automatic push_cmd(logic [3:0] a, logic [7:0] ch, logic [9:0] idx);
		edit_cmd_t c;
		c.action = a;
		c.char_in = ch;
		c.text_index = idx;
		pending_cmds.push_back(c);
	endtask

	// Pick a byte: mostly letters, often whitespace, sometimes anything.
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(99);
		if (r < 25) return ($urandom_range(1)) ? 8'h20 : 8'h0a;
		if (r < 85) return 8'(8'h61 + $urandom_range(25));
		return 8'($urandom_range(255));
	endfunction

	// Record each input transaction at the rising edge that takes it.
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			expected_results.push_back(apply_edit(pending_cmds.pop_front()));
			sent_count++;
		end
	end

	// Driver: change inputs at the falling edge; hold a stalled transaction.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_cmds.size() > 0 && (quiet_run || $urandom_range(99) >= 37)) begin
				in_valid <= 1'b1;
				action <= pending_cmds[0].action;
				char_in <= pending_cmds[0].char_in;
				text_index <= pending_cmds[0].text_index;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall, with one long hold-off to back up the input queue.
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off_cycles > 0) begin
				hold_off_cycles <= hold_off_cycles - 1;
				out_stall <= 1'b1;
			end else if (!hold_started && sent_count >= 40) begin
				hold_started <= 1'b1;
				hold_off_cycles <= 300;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !quiet_run && ($urandom_range(99) < 37);
			end
		end
	end

	// Monitor: compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		edit_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = expected_results.pop_front();
				if (cursor !== want.cursor)
					report_mismatch("cursor", int'(cursor), int'(want.cursor));
				if (length !== want.length)
					report_mismatch("length", int'(length), int'(want.length));
				if (read_char !== want.read_char)
					report_mismatch("read_char", int'(read_char), int'(want.read_char));
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
			end
		end
	end

	initial begin
		int n;
		int a;
		// directed: edges on an empty buffer, then short text with both delimiters
		push_cmd(tgb_pkg::ActDelete, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActBack, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActFwd, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActRead, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActFwdWord, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActDelWord, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActInsert, 8'hff, 10'd0);
		push_cmd(tgb_pkg::ActInsert, 8'h20, 10'd0);
		push_cmd(tgb_pkg::ActInsert, 8'h0a, 10'd0);
		push_cmd(tgb_pkg::ActInsert, 8'h41, 10'd0);
		push_cmd(tgb_pkg::ActInsert, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActRead, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActRead, 8'h00, 10'd4);
		push_cmd(tgb_pkg::ActRead, 8'h00, 10'd5);
		push_cmd(tgb_pkg::ActRead, 8'h00, 10'd1023);
		push_cmd(tgb_pkg::ActBackWord, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActBackWord, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActStart, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActFwdWord, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActEnd, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActBack, 8'h00, 10'd0);
		push_cmd(4'd15, 8'h00, 10'd0);
		push_cmd(4'd10, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActStart, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActDelWord, 8'h00, 10'd0);
		// random: typing-heavy mix; bytes tracked loosely to aim reads in range
		n = 5;
		for (int i = 0; i < 50; i++) begin
			a = $urandom_range(99);
			if (a < 45) begin
				push_cmd(tgb_pkg::ActInsert, pick_char(), 10'($urandom_range(1023)));
				n++;
			end else if (a < 90) begin
				push_cmd(4'($urandom_range(1, 9)), 8'($urandom_range(255)),
					($urandom_range(3) != 0 && n > 0) ? 10'($urandom_range(n))
						: 10'($urandom_range(1023)));
			end else begin
				push_cmd(4'($urandom_range(10, 15)), 8'($urandom_range(255)),
					10'($urandom_range(1023)));
			end
		end
		// fill the store to the top, hit the full case, read the last byte, drain some
		push_cmd(tgb_pkg::ActEnd, 8'h00, 10'd0);
		for (int i = 0; i < 1030; i++) push_cmd(tgb_pkg::ActInsert, pick_char(), 10'd0);
		push_cmd(tgb_pkg::ActRead, 8'h00, 10'd1023);
		push_cmd(tgb_pkg::ActStart, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActInsert, 8'h55, 10'd0);
		for (int i = 0; i < 20; i++) push_cmd(tgb_pkg::ActDelWord, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActEnd, 8'h00, 10'd0);
		push_cmd(tgb_pkg::ActBackWord, 8'h00, 10'd0);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (sent_count >= 500);
		quiet_run = 1'b1;
		wait (sent_count >= 700);
		quiet_run = 1'b0;
		wait (pending_cmds.size() == 0 && !in_valid);
		wait (expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Watchdog: long shifts of a full store bound the slow end of the run.
	initial begin
		#200ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
